// ===== rtl/mdco_pkg.sv =====
// Shared types and constants for the Manhattan-distance cell order scan.
// Used by the register block, controller, datapath and top level; depends on nothing.
package mdco_pkg;

  // Field and datapath widths
  localparam int DIM_W  = 8;   // grid dimension registers
  localparam int CEN_W  = 7;   // centre coordinate registers
  localparam int IDX_W  = 7;   // row and column fields of a result
  localparam int DIST_W = 8;   // distance field of a result
  localparam int CALC_W = 10;  // ring arithmetic: holds centre plus twice the largest span
  localparam int CNT_W  = 16;  // cells emitted; holds the largest possible cell count
  localparam int DATA_W = 32;  // configuration data bus
  localparam int ADDR_W = 4;   // configuration address bus

  // Largest value a dimension register can hold
  localparam int DIM_MAX = (1 << DIM_W) - 1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_NUM_ROWS   = 2'd0,
    REG_NUM_COLS   = 2'd1,
    REG_CENTER_ROW = 2'd2,
    REG_CENTER_COL = 2'd3
  } reg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  // Raw configuration register contents
  typedef struct packed {
    logic [DIM_W-1:0] num_rows;
    logic [DIM_W-1:0] num_cols;
    logic [CEN_W-1:0] center_row;
    logic [CEN_W-1:0] center_col;
  } cfg_t;

  // Commands from the controller to the datapath and output stage
  typedef struct packed {
    logic start;  // request beat taken this cycle
    logic step;   // examine one candidate cell
    logic load;   // move the finished result into the output register
  } cmd_t;

  // Status returned to the controller
  typedef struct packed {
    logic hit;       // the candidate examined this cycle produced the result
    logic out_free;  // output register can take a new result this cycle
  } sts_t;

  // One result beat
  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DIST_W-1:0] distance;
    logic              last;
    logic              done_res;
  } res_t;

endpackage

// ===== rtl/mdco_cfg.sv =====
// APB-style configuration registers for the cell order scan.
// Depends on mdco_pkg for the register indexes and the configuration struct.
module mdco_cfg import mdco_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              cfg_wr
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register writes during the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_rows   <= DIM_W'(1);
      cfg.num_cols   <= DIM_W'(1);
      cfg.center_row <= '0;
      cfg.center_col <= '0;
    end else if (cfg_wr) begin
      case (idx)
        REG_NUM_ROWS:   cfg.num_rows   <= pwdata[DIM_W-1:0];
        REG_NUM_COLS:   cfg.num_cols   <= pwdata[DIM_W-1:0];
        REG_CENTER_ROW: cfg.center_row <= pwdata[CEN_W-1:0];
        REG_CENTER_COL: cfg.center_col <= pwdata[CEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    case (idx)
      REG_NUM_ROWS:   prdata = DATA_W'(cfg.num_rows);
      REG_NUM_COLS:   prdata = DATA_W'(cfg.num_cols);
      REG_CENTER_ROW: prdata = DATA_W'(cfg.center_row);
      REG_CENTER_COL: prdata = DATA_W'(cfg.center_col);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/mdco_ctrl.sv =====
// Controller state machine for the cell order scan: sequences accept, scan and load.
// Depends on mdco_pkg for the state, command and status types.
module mdco_ctrl import mdco_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // Command decode from the current state.
  always_comb begin
    req_ready = (state == S_IDLE);
    cmd.start = (state == S_IDLE) && req_valid;
    cmd.step  = (state == S_SCAN);
    cmd.load  = (state == S_LOAD) && sts.out_free;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.hit) state_next = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/mdco_dp.sv =====
// Datapath of the cell order scan: grid geometry, ring walk state and the result register.
// Depends on mdco_pkg for widths, the configuration struct and the result struct.
module mdco_dp import mdco_pkg::*; #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cfg_wr,
  input  cmd_t cmd,
  input  logic restart,
  output logic hit,
  output res_t res
);

  localparam int ROW_LIM = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
  localparam int COL_LIM = (MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS;
  localparam logic [DIM_W-1:0] ROW_CAP = DIM_W'(ROW_LIM);
  localparam logic [DIM_W-1:0] COL_CAP = DIM_W'(COL_LIM);

  // Geometry derived from the registers
  logic [DIM_W-1:0]  rows_c, cols_c, rows_m1, cols_m1, cr_c, cc_c;
  logic [CALC_W-1:0] rows_q, cols_q, cr_q, cc_q, maxd_q;
  logic [CNT_W-1:0]  total_q;

  // Walk state
  logic [CALC_W-1:0] ring_distance, ring_distance_next;
  logic [CALC_W-1:0] ring_row, ring_row_next;
  logic              right_side, right_side_next;
  logic [CNT_W-1:0]  emitted_count, emitted_count_next;
  logic              exhausted, exhausted_next;
  logic              restart_pend;
  res_t              res_next;

  // Clamp the dimensions and centre; the geometry is registered every cycle.
  always_comb begin
    rows_c  = (cfg.num_rows == '0) ? DIM_W'(1) :
              ((cfg.num_rows > ROW_CAP) ? ROW_CAP : cfg.num_rows);
    cols_c  = (cfg.num_cols == '0) ? DIM_W'(1) :
              ((cfg.num_cols > COL_CAP) ? COL_CAP : cfg.num_cols);
    rows_m1 = rows_c - DIM_W'(1);
    cols_m1 = cols_c - DIM_W'(1);
    cr_c    = (DIM_W'(cfg.center_row) > rows_m1) ? rows_m1 : DIM_W'(cfg.center_row);
    cc_c    = (DIM_W'(cfg.center_col) > cols_m1) ? cols_m1 : DIM_W'(cfg.center_col);
  end

  always_ff @(posedge clk) begin
    rows_q  <= CALC_W'(rows_c);
    cols_q  <= CALC_W'(cols_c);
    cr_q    <= CALC_W'(cr_c);
    cc_q    <= CALC_W'(cc_c);
    maxd_q  <= CALC_W'(rows_m1) + CALC_W'(cols_m1);
    total_q <= CNT_W'(rows_c) * CNT_W'(cols_c);
  end

  // At most one candidate of the ring walk per step; a restart is applied as the beat is taken.
  always_comb begin
    logic [CALC_W-1:0] lo;
    logic [CALC_W-1:0] rr;
    logic [CALC_W-1:0] dr;
    logic [CALC_W-1:0] kk;
    logic [CALC_W-1:0] col_v;
    logic              past;
    logic              cell_ok;
    logic              fin;

    ring_distance_next = ring_distance;
    ring_row_next      = ring_row;
    right_side_next    = right_side;
    emitted_count_next = emitted_count;
    exhausted_next     = exhausted;
    res_next           = res;
    hit                = 1'b0;

    lo      = (cr_q > ring_distance) ? cr_q - ring_distance : '0;
    rr      = (ring_row < lo) ? lo : ring_row;
    past    = (rr >= rows_q) || (rr > cr_q + ring_distance);
    dr      = (rr > cr_q) ? rr - cr_q : cr_q - rr;
    kk      = ring_distance - dr;
    cell_ok = right_side ? (cc_q + kk < cols_q) : (kk <= cc_q);
    col_v   = right_side ? cc_q + kk : cc_q - kk;
    fin     = (emitted_count + CNT_W'(1)) >= total_q;

    if (cmd.start) begin
      // The centre row comes straight from the registers, so a write just before is seen.
      if (restart || restart_pend) begin
        ring_distance_next = '0;
        ring_row_next      = CALC_W'(cr_c);
        right_side_next    = 1'b0;
        emitted_count_next = '0;
        exhausted_next     = 1'b0;
      end
    end else if (cmd.step) begin
      if (exhausted || (ring_distance > maxd_q)) begin
        // Sequence finished: answer with a done beat.
        exhausted_next = 1'b1;
        hit            = 1'b1;
        res_next       = '{row: '0, col: '0, distance: '0, last: 1'b0, done_res: 1'b1};
      end else if (past) begin
        // Ring has no rows left inside the grid: move to the next ring.
        ring_distance_next = ring_distance + CALC_W'(1);
        ring_row_next      = '0;
        right_side_next    = 1'b0;
      end else begin
        // Left candidate first, then the right one unless both coincide.
        if (!right_side && (kk != '0)) begin
          ring_row_next   = rr;
          right_side_next = 1'b1;
        end else begin
          ring_row_next   = rr + CALC_W'(1);
          right_side_next = 1'b0;
        end
        if (cell_ok) begin
          hit                = 1'b1;
          emitted_count_next = emitted_count + CNT_W'(1);
          exhausted_next     = fin;
          res_next.row       = rr[IDX_W-1:0];
          res_next.col       = col_v[IDX_W-1:0];
          res_next.distance  = ring_distance[DIST_W-1:0];
          res_next.last      = fin;
          res_next.done_res  = 1'b0;
        end
      end
    end
  end

  // Walk state and pending restart after a register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_distance <= '0;
      ring_row      <= '0;
      right_side    <= 1'b0;
      emitted_count <= '0;
      exhausted     <= 1'b0;
      restart_pend  <= 1'b1;
    end else begin
      ring_distance <= ring_distance_next;
      ring_row      <= ring_row_next;
      right_side    <= right_side_next;
      emitted_count <= emitted_count_next;
      exhausted     <= exhausted_next;
      if (cfg_wr) begin
        restart_pend <= 1'b1;
      end else if (cmd.start) begin
        restart_pend <= 1'b0;
      end
    end
  end

  // Result register: payload only.
  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// ===== rtl/manhattan_distance_cell_order.sv =====
// Manhattan-distance cell order scan: top level with the output register and checks.
// A request beat is taken in S_IDLE; S_SCAN then examines candidate cells one by one
// (at least one) until the result is found, and S_LOAD moves it into the output register
// once it is free; a scan runs longer where a ring holds cells or rows outside the grid.
// A new request is taken while a finished result still waits in the output register.
// Reset (synchronous): grid 1 x 1, centre at the origin, scan at its start, output empty.
module manhattan_distance_cell_order import mdco_pkg::*; #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              restart,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [IDX_W-1:0]  row,
  output logic [IDX_W-1:0]  col,
  output logic [DIST_W-1:0] distance,
  output logic              last,
  output logic              done_res
);

  cfg_t cfg;
  logic cfg_wr;
  cmd_t cmd;
  sts_t sts;
  logic dp_hit;
  res_t dp_res;
  res_t out_q;

  mdco_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  mdco_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mdco_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr),
    .cmd     (cmd),
    .restart (restart),
    .hit     (dp_hit),
    .res     (dp_res)
  );

  // Status back to the controller.
  assign sts.hit      = dp_hit;
  assign sts.out_free = !res_valid || res_ready;

  // Output register: holds one result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_q <= dp_res;
    end
  end

  assign row      = out_q.row;
  assign col      = out_q.col;
  assign distance = out_q.distance;
  assign last     = out_q.last;
  assign done_res = out_q.done_res;

  // A result is only moved into the output register when that register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!res_valid || res_ready))
    else $error("result loaded over an untaken beat");

  // A request beat taken starts the scan in the next cycle.
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (cmd.step && !req_ready))
    else $error("scan did not follow an accepted request");

  // A load is followed by a valid result beat.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> res_valid)
    else $error("loaded result not presented");

  // A done beat carries no cell.
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && done_res) |-> (row == '0 && col == '0 && distance == '0 && !last))
    else $error("done beat carries cell data");

endmodule

// ===== verif/cell_order_checker.sv =====
// Checker for the Manhattan-distance cell order scan: follows the register writes and both
// beat channels, predicts every result beat and compares it field by field.
// Depends on mdco_pkg for the register indexes, widths and the result layout.
module cell_order_checker import mdco_pkg::*; #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              req_valid,
  input  logic              req_ready,
  input  logic              restart,
  input  logic              res_valid,
  input  logic              res_ready,
  input  logic [IDX_W-1:0]  row,
  input  logic [IDX_W-1:0]  col,
  input  logic [DIST_W-1:0] distance,
  input  logic              last,
  input  logic              done_res,
  output int                fail_count,
  output int                pending
);

  // Shadow copy of the configuration registers.
  logic [DIM_W-1:0] grid_rows;
  logic [DIM_W-1:0] grid_cols;
  logic [CEN_W-1:0] centre_row;
  logic [CEN_W-1:0] centre_col;

  // Position of the walk: current ring, row within it and which side of the centre column.
  logic [DIST_W-1:0] walk_ring;
  logic [7:0]        walk_row;
  logic              walk_right;
  logic [CNT_W-1:0]  cells_given;
  logic              walk_over;

  res_t cells_due[$];
  int   beats_seen;

  // A dimension of zero counts as one; anything above the maximum is cut down to it.
  function automatic int unsigned grid_span(input logic [DIM_W-1:0] n, input int unsigned lim);
    if (n == 0) return 1;
    if (n > lim) return lim;
    return n;
  endfunction

  // A centre beyond the grid is pulled back to the last row or column.
  function automatic int unsigned centre_in(input logic [CEN_W-1:0] c, input int unsigned n);
    return (c > n - 1) ? n - 1 : c;
  endfunction

  function automatic void rewind_walk();
    walk_ring   = '0;
    walk_row    = centre_in(centre_row, grid_span(grid_rows, MAX_ROWS));
    walk_right  = 1'b0;
    cells_given = '0;
    walk_over   = 1'b0;
  endfunction

  // Works out the result of one request and moves the walk on past the cell it gives.
  function automatic res_t next_cell(input logic rs);
    int unsigned rows, cols, cr, cc, maxd, total, d, lo, dr, k, r, c;
    logic hit;
    res_t res;
    rows  = grid_span(grid_rows, MAX_ROWS);
    cols  = grid_span(grid_cols, MAX_COLS);
    cr    = centre_in(centre_row, rows);
    cc    = centre_in(centre_col, cols);
    maxd  = (rows - 1) + (cols - 1);
    total = rows * cols;
    res = '0;
    res.done_res = 1'b1;
    if (rs) rewind_walk();
    if (walk_over) return res;
    while (1'b1) begin
      d = walk_ring;
      if (d > maxd) begin
        walk_over = 1'b1;
        return res;
      end
      lo = (cr > d) ? cr - d : 0;
      if (walk_row < lo) walk_row = lo;
      if (walk_row >= rows || walk_row > cr + d) begin
        // This ring has no rows left inside the grid: move out to the next one.
        walk_ring  = d + 1;
        walk_row   = '0;
        walk_right = 1'b0;
      end else begin
        r  = walk_row;
        dr = (r > cr) ? r - cr : cr - r;
        k  = d - dr;
        if (!walk_right) begin
          // Left candidate; on the centre column it is the only one of the row.
          hit = (k <= cc);
          c   = cc - k;
          if (k == 0) walk_row = r + 1;
          else walk_right = 1'b1;
        end else begin
          hit        = (cc + k < cols);
          c          = cc + k;
          walk_right = 1'b0;
          walk_row   = r + 1;
        end
        if (hit) begin
          cells_given  = cells_given + 1'b1;
          res.row      = r[IDX_W-1:0];
          res.col      = c[IDX_W-1:0];
          res.distance = d[DIST_W-1:0];
          res.done_res = 1'b0;
          res.last     = (cells_given >= total);
          if (res.last) walk_over = 1'b1;
          return res;
        end
      end
    end
    return res;
  endfunction

  task automatic report(input string what);
    $display("mismatch on result beat %0d: %s", beats_seen, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    if (rst) begin
      grid_rows  = 8'd1;
      grid_cols  = 8'd1;
      centre_row = '0;
      centre_col = '0;
      rewind_walk();
      cells_due.delete();
      beats_seen = 0;
      fail_count = 0;
      pending <= 0;
    end else begin
      // Result beats are checked against the oldest prediction.
      if (res_valid && res_ready) begin
        seen.row      = row;
        seen.col      = col;
        seen.distance = distance;
        seen.last     = last;
        seen.done_res = done_res;
        if (cells_due.size() == 0) begin
          report("result beat with no request outstanding");
        end else begin
          want = cells_due.pop_front();
          if (seen.row !== want.row)
            report($sformatf("row %0d, predicted %0d", seen.row, want.row));
          if (seen.col !== want.col)
            report($sformatf("col %0d, predicted %0d", seen.col, want.col));
          if (seen.distance !== want.distance)
            report($sformatf("distance %0d, predicted %0d", seen.distance, want.distance));
          if (seen.last !== want.last)
            report($sformatf("last %0b, predicted %0b", seen.last, want.last));
          if (seen.done_res !== want.done_res)
            report($sformatf("done_res %0b, predicted %0b", seen.done_res, want.done_res));
        end
        beats_seen++;
      end

      // A register write also puts the walk back at the centre.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_NUM_ROWS:   grid_rows  = pwdata[DIM_W-1:0];
          REG_NUM_COLS:   grid_cols  = pwdata[DIM_W-1:0];
          REG_CENTER_ROW: centre_row = pwdata[CEN_W-1:0];
          REG_CENTER_COL: centre_col = pwdata[CEN_W-1:0];
          default: ;
        endcase
        rewind_walk();
      end

      if (req_valid && req_ready) cells_due.push_back(next_cell(restart));

      pending <= cells_due.size();
    end
  end

endmodule

// ===== verif/manhattan_distance_cell_order_tb.sv =====
// Testbench top for the Manhattan-distance cell order scan: clock, reset, register writes,
// request beats with random gaps and result back-pressure, and the final verdict.
// Depends on mdco_pkg, the block itself and cell_order_checker.
module manhattan_distance_cell_order_tb;
  import mdco_pkg::*;

  localparam int IDLE_PCT     = 19;
  localparam int SETTLE       = 16;
  localparam int TARGET_ITEMS = 1300;
  // The slowest legal beat scans the rings of a 128 x 128 grid and also meets stalls; the limit
  // covers every beat of the run being that slow several times.
  localparam int CYCLE_LIMIT  = 2000000;

  logic              clk;
  logic              rst       = 1'b1;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic              restart   = 1'b0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  logic [DIST_W-1:0] distance;
  logic              last;
  logic              done_res;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  logic        steady      = 1'b0;

  manhattan_distance_cell_order i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .restart   (restart),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .row       (row),
    .col       (col),
    .distance  (distance),
    .last      (last),
    .done_res  (done_res)
  );

  cell_order_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .restart    (restart),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .row        (row),
    .col        (col),
    .distance   (distance),
    .last       (last),
    .done_res   (done_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure; none while a steady stretch runs.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Same saturation as the block applies to a dimension register.
  function automatic int unsigned span_of(input logic [DIM_W-1:0] n);
    if (n == 0) return 1;
    if (n > 128) return 128;
    return n;
  endfunction

  function automatic logic [DIM_W-1:0] edge_dim();
    case ($urandom_range(0, 6))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd2;
      3:       return 8'd127;
      4:       return 8'd128;
      5:       return 8'd129;
      default: return 8'd255;
    endcase
  endfunction

  // Waits until every predicted beat has come back.
  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  // Setup phase, access phase until pready, then a return to idle; bits above the register are noise.
  task automatic apb_write(input reg_idx_t idx, input logic [DIM_W-1:0] value);
    logic [DATA_W-1:0] noise;
    int unsigned       w;
    noise = $urandom();
    w = (idx == REG_NUM_ROWS || idx == REG_NUM_COLS) ? DIM_W : CEN_W;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (noise & ~((32'd1 << w) - 1)) | value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are only touched once the block has gone quiet.
  task automatic load_grid(input logic [DIM_W-1:0] nr, input logic [DIM_W-1:0] nc,
                           input logic [CEN_W-1:0] cr, input logic [CEN_W-1:0] cc,
                           input logic [3:0] which);
    req_valid <= 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);
    if (which[REG_NUM_ROWS])   apb_write(REG_NUM_ROWS, nr);
    if (which[REG_NUM_COLS])   apb_write(REG_NUM_COLS, nc);
    if (which[REG_CENTER_ROW]) apb_write(REG_CENTER_ROW, {1'b0, cr});
    if (which[REG_CENTER_COL]) apb_write(REG_CENTER_COL, {1'b0, cc});
  endtask

  // One request beat, after an occasional gap; valid stays up for the next beat.
  task automatic send_request(input logic rs);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_valid <= 1'b1;
    restart   <= rs;
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  task automatic walk(input int unsigned n, input int unsigned restart_pct,
                      input logic pause_mid);
    for (int unsigned i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        req_valid <= 1'b0;
        drain();
      end
      send_request($urandom_range(0, 99) < restart_pct);
    end
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] nr, nc;
    logic [CEN_W-1:0] cr, cc;
    logic [3:0]       which;
    int unsigned      er, ec, n, sel;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Grid of one cell straight out of reset: the cell, then done twice, then a restart.
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);

    // 3 x 3 around the middle: ring order and tie order, exhaustion, restart after done.
    load_grid(8'd3, 8'd3, 7'd1, 7'd1, 4'hF);
    repeat (10) send_request(1'b0);
    send_request(1'b1);

    // Zero rows count as one, 255 columns saturate, centre row beyond the grid, centre column on the last column.
    load_grid(8'd0, 8'd255, 7'd127, 7'd127, 4'hF);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    // A write part way through a walk starts it again from the new centre.
    load_grid(8'd0, 8'd0, 7'd0, 7'd5, 4'b1000);
    repeat (2) send_request(1'b0);

    // Long walks that reach row 127, column 127 and distances past 127, no idling in the first.
    steady <= 1'b1;
    load_grid(8'd128, 8'd2, 7'd0, 7'd0, 4'hF);
    walk(258, 0, 1'b0);
    steady <= 1'b0;
    load_grid(8'd2, 8'd128, 7'd1, 7'd127, 4'hF);
    walk(258, 0, 1'b1);

    // Random grids, mostly small so that walks run to the end, some at the edges.
    while (items_sent < TARGET_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        nr = $urandom_range(1, 10);
        nc = $urandom_range(1, 10);
      end else if (sel < 85) begin
        nr = $urandom_range(1, 40);
        nc = $urandom_range(1, 40);
      end else begin
        nr = edge_dim();
        nc = edge_dim();
      end
      er = span_of(nr);
      ec = span_of(nc);
      cr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, er - 1);
      cc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, ec - 1);
      which = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 4'hF;
      load_grid(nr, nc, cr, cc, which);
      n = (er * ec <= 40) ? er * ec + $urandom_range(1, 4) : $urandom_range(10, 40);
      walk(n, 2, 1'b0);
    end

    req_valid <= 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
